@@ hw/rtl/pic_pkg.sv @@
`timescale 1ns / 1ps

package pic_pkg;

  // width of every field on the ports
  localparam int IO_W = 32;

  // configuration register count and index width
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  // status of the shared serial multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ hw/rtl/pic_serial_mul.sv @@
`timescale 1ns / 1ps

module pic_serial_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output pic_pkg::mul_stat_t           stat,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW + 1;
  localparam int CW = $clog2(DW + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW - 1){1'b0}}};

  logic          busy;
  logic          fin;
  logic          done;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] ua;
  logic [DW-1:0] hi;
  logic [DW-1:0] lo;

  logic [DW:0]        step_sum;
  logic [PW-1:0]      rnd;
  logic               over;
  logic [DW-1:0]      mag;
  logic signed [DW-1:0] res_next;

  // one multiplier bit per cycle: add magnitude, shift product right
  always_comb begin
    step_sum = {1'b0, hi} + (lo[0] ? {1'b0, ua} : '0);
  end

  // round half away from zero on the magnitude, then saturate and sign
  always_comb begin
    rnd  = {1'b0, hi, lo} + HALF;
    over = |rnd[PW-1:FRAC_BITS+DW-1];
    mag  = {1'b0, rnd[FRAC_BITS+DW-2:FRAC_BITS]};
    if (over) begin
      res_next = neg ? MINV : MAXV;
    end else begin
      res_next = neg ? -signed'(mag) : signed'(mag);
    end
  end

  // sequencing of the shift-add passes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
      end
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[DW-1] ^ b[DW-1];
      ua  <= a[DW-1] ? (~a + 1'b1) : a;
      lo  <= b[DW-1] ? (~b + 1'b1) : b;
      hi  <= '0;
    end else if (busy) begin
      hi <= step_sum[DW:1];
      lo <= {step_sum[0], lo[DW-1:1]};
    end
    if (fin) begin
      result <= res_next;
    end
  end

  assign stat.busy = busy | fin;
  assign stat.done = done;

endmodule

@@ hw/rtl/pi_current_loop_feedforward_unit.sv @@
`timescale 1ns / 1ps

// PI current loop with back-calculation anti-windup, friction compensation
// and speed feedforward, signed fixed point with FRAC_BITS fraction bits.
// Input channel: in_valid / in_stall carries torque_ref, measured_current
// and speed_rpm; a transaction is taken when in_valid is high and in_stall
// low. Output channel: out_valid / out_stall carries drive_output,
// current_error and current_reference from an output register.
// Gains are written through wr_en / wr_index / wr_data, by the user only
// while idle; the block itself does not enforce it. Each sample runs seven
// products through one bit-serial multiplier that retires one multiplier
// bit per cycle; in_stall is high from acceptance of a sample until its
// result enters the output register. The next sample may be accepted
// while a result still waits.
// If the receiver stalls with a result pending, the following result is
// held internally until the output register frees.
// Reset clears the gains, the integrator and the previous drive to zero
// and empties the output register.

module pi_current_loop_feedforward_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pic_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [pic_pkg::IO_W-1:0]      wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pic_pkg::IO_W-1:0]      torque_ref,
  input  logic [pic_pkg::IO_W-1:0]      measured_current,
  input  logic [pic_pkg::IO_W-1:0]      speed_rpm,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pic_pkg::IO_W-1:0]      drive_output,
  output logic [pic_pkg::IO_W-1:0]      current_error,
  output logic [pic_pkg::IO_W-1:0]      current_reference
);

  localparam int DW = DATA_WIDTH;
  localparam int SW = DATA_WIDTH + 2;
  localparam int EW = (DATA_WIDTH > pic_pkg::IO_W) ? DATA_WIDTH : pic_pkg::IO_W;

  // register indexes
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_PROP   = 3'd0;
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_INTEG  = 3'd1;
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_WINDUP = 3'd2;
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_VISC   = 3'd4;
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_CFRIC  = 3'd5;
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_SCALE  = 3'd6;
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_FFWD   = 3'd7;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // product steps
  localparam logic [2:0] STEP_FRIC   = 3'd0;
  localparam logic [2:0] STEP_IREF   = 3'd1;
  localparam logic [2:0] STEP_WINDUP = 3'd2;
  localparam logic [2:0] STEP_INTEG  = 3'd3;
  localparam logic [2:0] STEP_PROP   = 3'd4;
  localparam logic [2:0] STEP_IGAIN  = 3'd5;
  localparam logic [2:0] STEP_FFWD   = 3'd6;

  function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi_lim;
    logic signed [SW-1:0] lo_lim;
    hi_lim = signed'({2'b00, 1'b0, {(DW - 1){1'b1}}});
    lo_lim = signed'({2'b11, 1'b1, {(DW - 1){1'b0}}});
    if (v > hi_lim) begin
      sat = hi_lim[DW-1:0];
    end else if (v < lo_lim) begin
      sat = lo_lim[DW-1:0];
    end else begin
      sat = v[DW-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [DW-1:0] v);
    ext = signed'({{2{v[DW-1]}}, v});
  endfunction

  // 32-bit port value into the internal format, saturating when narrower
  function automatic logic signed [DW-1:0] from_port(input logic [pic_pkg::IO_W-1:0] v);
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] hi_lim;
    logic signed [EW-1:0] lo_lim;
    e      = EW'(signed'(v));
    hi_lim = EW'(signed'({1'b0, {(DW - 1){1'b1}}}));
    lo_lim = EW'(signed'({1'b1, {(DW - 1){1'b0}}}));
    if (e > hi_lim) begin
      from_port = hi_lim[DW-1:0];
    end else if (e < lo_lim) begin
      from_port = lo_lim[DW-1:0];
    end else begin
      from_port = e[DW-1:0];
    end
  endfunction

  function automatic logic [pic_pkg::IO_W-1:0] to_port(input logic signed [DW-1:0] v);
    logic signed [EW-1:0] e;
    e       = EW'(v);
    to_port = e[pic_pkg::IO_W-1:0];
  endfunction

  logic signed [DW-1:0] cfg_reg [pic_pkg::NUM_REGS];
  logic [1:0]           state;
  logic [2:0]           step;
  logic signed [DW-1:0] tref;
  logic signed [DW-1:0] meas;
  logic signed [DW-1:0] spd;
  logic signed [DW-1:0] fric;
  logic signed [DW-1:0] iref;
  logic signed [DW-1:0] err;
  logic signed [DW-1:0] delta;
  logic signed [DW-1:0] integ_new;
  logic signed [DW-1:0] drive;
  logic signed [SW-1:0] acc;
  logic signed [DW-1:0] integrator;
  logic signed [DW-1:0] prev_drive;
  logic signed [DW-1:0] out_drive;
  logic signed [DW-1:0] out_err;
  logic signed [DW-1:0] out_iref;

  logic                 mul_start;
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [DW-1:0] mul_res;
  pic_pkg::mul_stat_t   mul_stat;
  logic signed [DW-1:0] torque;
  logic                 out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pic_pkg::NUM_REGS; i++) begin
        cfg_reg[i] <= '0;
      end
    end else if (wr_en) begin
      cfg_reg[wr_index] <= from_port(wr_data);
    end
  end

  assign torque    = sat(ext(tref) - ext(fric));
  assign mul_start = (state == ST_START);
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // operand select per product step
  always_comb begin
    unique case (step)
      STEP_FRIC: begin
        mul_a = cfg_reg[REG_VISC];
        mul_b = spd;
      end
      STEP_IREF: begin
        mul_a = torque;
        mul_b = cfg_reg[REG_SCALE];
      end
      STEP_WINDUP: begin
        mul_a = cfg_reg[REG_WINDUP];
        mul_b = prev_drive;
      end
      STEP_INTEG: begin
        mul_a = delta;
        mul_b = cfg_reg[REG_PERIOD];
      end
      STEP_PROP: begin
        mul_a = cfg_reg[REG_PROP];
        mul_b = err;
      end
      STEP_IGAIN: begin
        mul_a = cfg_reg[REG_INTEG];
        mul_b = integ_new;
      end
      STEP_FFWD: begin
        mul_a = cfg_reg[REG_FFWD];
        mul_b = spd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pic_serial_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .result(mul_res)
  );

  // sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= STEP_FRIC;
      out_valid  <= 1'b0;
      integrator <= '0;
      prev_drive <= '0;
    end else begin
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            step  <= STEP_FRIC;
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_stat.done) begin
            if (step == STEP_FFWD) begin
              state <= ST_FIN;
            end else begin
              step  <= step + 1'b1;
              state <= ST_START;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            integrator <= integ_new;
            prev_drive <= drive;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // sample capture and per-step datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      tref <= from_port(torque_ref);
      meas <= from_port(measured_current);
      spd  <= from_port(speed_rpm);
    end
    if (state == ST_WAIT && mul_stat.done) begin
      unique case (step)
        STEP_FRIC:   fric <= sat(ext(mul_res) + ext(cfg_reg[REG_CFRIC]));
        STEP_IREF: begin
          iref <= mul_res;
          err  <= sat(ext(mul_res) - ext(meas));
        end
        STEP_WINDUP: delta     <= sat(ext(err) - ext(mul_res));
        STEP_INTEG:  integ_new <= sat(ext(integrator) + ext(mul_res));
        STEP_PROP:   acc       <= ext(mul_res);
        STEP_IGAIN:  acc       <= acc + ext(mul_res);
        STEP_FFWD:   drive     <= sat(acc + ext(mul_res));
        default:     acc       <= acc;
      endcase
    end
    if (state == ST_FIN && out_free) begin
      out_drive <= drive;
      out_err   <= err;
      out_iref  <= iref;
    end
  end

  assign drive_output      = to_port(out_drive);
  assign current_error     = to_port(out_err);
  assign current_reference = to_port(out_iref);

  // the multiplier is only started when it is free
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // a product only completes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> state == ST_WAIT)
    else $error("product completed outside wait state");

  // a new result only appears after the final step
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result raised outside final state");

  // the step counter never runs past the last product
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> step <= STEP_FFWD)
    else $error("step out of range");

endmodule
